[design/kteo_pkg.sv]
package kteo_pkg;

  localparam int unsigned TABLE_ENTRIES = 8;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int unsigned KEY_W = 32;
  localparam int unsigned SRC_W = 2;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned SLOT_W = 3;
  localparam int unsigned OUT_CNT_W = 4;

  localparam logic [KEY_W-1:0] FREE_KEY = {KEY_W{1'b1}};
  localparam logic [SRC_W-1:0] SRC_OTHER = 2'd0;
  localparam logic [SRC_W-1:0] SRC_UNUSED = 2'd3;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_NEWEST = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    SCAN_ADD,
    SCAN_REMOVE,
    SCAN_NEWEST
  } scan_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic start;
    logic step;
    scan_mode_e mode;
    logic [IDX_W-1:0] idx;
  } scan_ctrl_t;

  typedef struct packed {
    logic hit;
    logic [IDX_W-1:0] pick;
    logic [KEY_W-1:0] best;
    logic [SRC_W-1:0] src;
    logic free_hit;
    logic [IDX_W-1:0] free_pick;
  } scan_res_t;

  typedef struct packed {
    logic en;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
    logic [SRC_W-1:0] src;
  } tbl_wr_t;

endpackage

[design/kteo_table.sv]
module kteo_table
  import kteo_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] rd_idx_i,
  output logic [KEY_W-1:0] rd_key_o,
  output logic [SRC_W-1:0] rd_src_o,
  input  tbl_wr_t          wr_i
);

  logic [KEY_W-1:0] keys_q [TABLE_ENTRIES];
  logic [SRC_W-1:0] srcs_q [TABLE_ENTRIES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        keys_q[i] <= FREE_KEY;
        srcs_q[i] <= SRC_OTHER;
      end
    end else if (wr_i.en) begin
      keys_q[wr_i.idx] <= wr_i.key;
      srcs_q[wr_i.idx] <= wr_i.src;
    end
  end

  assign rd_key_o = keys_q[rd_idx_i];
  assign rd_src_o = srcs_q[rd_idx_i];

endmodule

[design/kteo_scan.sv]
module kteo_scan
  import kteo_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  scan_ctrl_t       ctrl_i,
  input  logic [KEY_W-1:0] key_ref_i,
  input  logic [KEY_W-1:0] rd_key_i,
  input  logic [SRC_W-1:0] rd_src_i,
  output scan_res_t        res_o
);

  logic             hit_q, hit_d;
  logic             free_hit_q, free_hit_d;
  logic [IDX_W-1:0] pick_q, pick_d;
  logic [IDX_W-1:0] free_pick_q, free_pick_d;
  logic [KEY_W-1:0] best_q, best_d;
  logic [SRC_W-1:0] src_q, src_d;

  logic             is_free;
  logic             is_eq;
  logic             is_better;
  logic [KEY_W-1:0] cmp_a;
  logic [KEY_W-1:0] cmp_b;
  logic             take;

  always_comb begin
    is_free = (rd_key_i == FREE_KEY);
    is_eq = (rd_key_i == key_ref_i);
    if (ctrl_i.mode == SCAN_NEWEST) begin
      cmp_a = best_q;
      cmp_b = rd_key_i;
    end else begin
      cmp_a = rd_key_i;
      cmp_b = best_q;
    end
    is_better = (cmp_a < cmp_b);

    unique case (ctrl_i.mode)
      SCAN_ADD:    take = !is_free && (!hit_q || is_better);
      SCAN_REMOVE: take = is_eq && !hit_q;
      SCAN_NEWEST: take = !is_free && (!hit_q || is_better);
      default:     take = 1'b0;
    endcase

    hit_d = hit_q;
    pick_d = pick_q;
    best_d = best_q;
    src_d = src_q;
    free_hit_d = free_hit_q;
    free_pick_d = free_pick_q;

    if (ctrl_i.start) begin
      hit_d = 1'b0;
      free_hit_d = 1'b0;
    end else if (ctrl_i.step) begin
      if (take) begin
        hit_d = 1'b1;
        pick_d = ctrl_i.idx;
        best_d = rd_key_i;
        src_d = rd_src_i;
      end
      if (ctrl_i.mode == SCAN_ADD && is_free && !free_hit_q) begin
        free_hit_d = 1'b1;
        free_pick_d = ctrl_i.idx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      free_hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
      free_hit_q <= free_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pick_q <= pick_d;
    best_q <= best_d;
    src_q <= src_d;
    free_pick_q <= free_pick_d;
  end

  assign res_o = '{hit: hit_q, pick: pick_q, best: best_q, src: src_q,
                   free_hit: free_hit_q, free_pick: free_pick_q};

`ifndef SYNTHESIS
  a_newest_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.step && ctrl_i.mode == SCAN_NEWEST && hit_q |-> best_q != FREE_KEY)
    else $error("newest scan holds a free key as its best entry");
`endif

endmodule

[design/keyed_table_evict_oldest.sv]
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o   | func_i, item_id_i, source_kind_i
// out     | output    | out_valid_o / out_stall_i | status_o, slot_o, evicted_o,
//         |           |                           | evicted_id_o, found_id_o,
//         |           |                           | found_source_o, entry_count_o
//
// The scan reads one table entry per cycle through a single compare unit, so the result is
// registered as ST_FINISH is left, once every entry has been read, and the input is ready
// again in the cycle after, back in ST_IDLE; no new item is taken before then. Items that
// need no scan (rejected adds and removes, unused operations) go straight to ST_FINISH.
// The table resets to all slots free with a count of zero; no clearing pass is needed.
// A result waits in the output register while out_stall_i is high, and the next item
// is accepted meanwhile but cannot finish until that result is taken.
module keyed_table_evict_oldest
  import kteo_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [FUNC_W-1:0]    func_i,
  input  logic [KEY_W-1:0]     item_id_i,
  input  logic [SRC_W-1:0]     source_kind_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 status_o,
  output logic [SLOT_W-1:0]    slot_o,
  output logic                 evicted_o,
  output logic [KEY_W-1:0]     evicted_id_o,
  output logic [KEY_W-1:0]     found_id_o,
  output logic [SRC_W-1:0]     found_source_o,
  output logic [OUT_CNT_W-1:0] entry_count_o
);

  state_e state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [FUNC_W-1:0] func_q;
  logic [KEY_W-1:0] key_q;
  logic [SRC_W-1:0] src_q;
  logic skip_q;
  logic out_valid_q, out_valid_d;

  logic accept;
  logic skip;
  logic finish;
  logic out_free;
  scan_ctrl_t scan_ctrl;
  scan_res_t scan_res;
  tbl_wr_t wr;
  logic [KEY_W-1:0] rd_key;
  logic [SRC_W-1:0] rd_src;

  logic res_status;
  logic [IDX_W-1:0] res_pick;
  logic res_evicted;
  logic [KEY_W-1:0] res_evicted_id;
  logic [KEY_W-1:0] res_found_id;
  logic [SRC_W-1:0] res_found_src;

  logic status_q;
  logic [SLOT_W-1:0] slot_q;
  logic evicted_q;
  logic [KEY_W-1:0] evicted_id_q;
  logic [KEY_W-1:0] found_id_q;
  logic [SRC_W-1:0] found_src_q;

  kteo_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (idx_q),
    .rd_key_o (rd_key),
    .rd_src_o (rd_src),
    .wr_i     (wr)
  );

  kteo_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (scan_ctrl),
    .key_ref_i (key_q),
    .rd_key_i  (rd_key),
    .rd_src_i  (rd_src),
    .res_o     (scan_res)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign finish = (state_q == ST_FINISH) && out_free;
  assign skip = !((func_i == FUNC_ADD && item_id_i != FREE_KEY) ||
                  (func_i == FUNC_REMOVE && item_id_i != FREE_KEY) ||
                  (func_i == FUNC_NEWEST));

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    scan_ctrl.start = accept;
    scan_ctrl.step = (state_q == ST_SCAN);
    scan_ctrl.idx = idx_q;
    unique case (func_q)
      FUNC_ADD:    scan_ctrl.mode = SCAN_ADD;
      FUNC_REMOVE: scan_ctrl.mode = SCAN_REMOVE;
      default:     scan_ctrl.mode = SCAN_NEWEST;
    endcase

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d = '0;
          state_d = skip ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == IDX_W'(TABLE_ENTRIES - 1)) begin
          idx_d = '0;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    res_status = STATUS_MISS;
    res_pick = '0;
    res_evicted = 1'b0;
    res_evicted_id = '0;
    res_found_id = key_q;
    res_found_src = SRC_OTHER;
    count_d = count_q;
    wr = '{en: 1'b0, idx: '0, key: key_q, src: src_q};

    if (!skip_q) begin
      priority if (func_q == FUNC_ADD) begin
        res_status = STATUS_OK;
        res_found_src = src_q;
        if (scan_res.free_hit) begin
          res_pick = scan_res.free_pick;
          count_d = count_q + 1'b1;
        end else begin
          res_pick = scan_res.pick;
          res_evicted = 1'b1;
          res_evicted_id = scan_res.best;
        end
        wr = '{en: finish, idx: res_pick, key: key_q, src: src_q};
      end else if (func_q == FUNC_REMOVE) begin
        if (scan_res.hit) begin
          res_status = STATUS_OK;
          res_pick = scan_res.pick;
          res_found_src = scan_res.src;
          count_d = count_q - 1'b1;
          wr = '{en: finish, idx: scan_res.pick, key: FREE_KEY, src: scan_res.src};
        end
      end else begin
        res_found_id = '0;
        if (scan_res.hit) begin
          res_status = STATUS_OK;
          res_pick = scan_res.pick;
          res_found_id = scan_res.best;
          res_found_src = scan_res.src;
        end
      end
    end

    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q <= '0;
      count_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      out_valid_q <= out_valid_d;
      if (finish) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      key_q <= item_id_i;
      src_q <= (source_kind_i == SRC_UNUSED) ? SRC_OTHER : source_kind_i;
      skip_q <= skip;
    end
    if (finish) begin
      status_q <= res_status;
      slot_q <= SLOT_W'(res_pick);
      evicted_q <= res_evicted;
      evicted_id_q <= res_evicted_id;
      found_id_q <= res_found_id;
      found_src_q <= res_found_src;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o = status_q;
  assign slot_o = slot_q;
  assign evicted_o = evicted_q;
  assign evicted_id_o = evicted_id_q;
  assign found_id_o = found_id_q;
  assign found_source_o = found_src_q;
  assign entry_count_o = OUT_CNT_W'(count_q);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count exceeds the table size");

  a_evict_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && evicted_q |-> count_q == CNT_W'(TABLE_ENTRIES))
    else $error("eviction reported while the table is not full");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> count_q == $past(count_q) || count_q == $past(count_q) + 1'b1 ||
               count_q == $past(count_q) - 1'b1)
    else $error("entry count moved by more than one per item");

  a_scan_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN && idx_q == IDX_W'(TABLE_ENTRIES - 1) |=> state_q == ST_FINISH)
    else $error("scan did not end after the last entry");
`endif

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import kteo_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [SRC_W-1:0] SRC_CHAT = 2'd1;
  localparam logic [SRC_W-1:0] SRC_MAIL = 2'd2;
  localparam int unsigned CYCLE_LIMIT = 500_000;

  typedef struct packed {
    logic                 status;
    logic [SLOT_W-1:0]    slot;
    logic                 evicted;
    logic [KEY_W-1:0]     evicted_id;
    logic [KEY_W-1:0]     found_id;
    logic [SRC_W-1:0]     found_source;
    logic [OUT_CNT_W-1:0] entry_count;
  } table_reply_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [FUNC_W-1:0]    func_i = FUNC_ADD;
  logic [KEY_W-1:0]     item_id_i = '0;
  logic [SRC_W-1:0]     source_kind_i = SRC_OTHER;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 status_o;
  logic [SLOT_W-1:0]    slot_o;
  logic                 evicted_o;
  logic [KEY_W-1:0]     evicted_id_o;
  logic [KEY_W-1:0]     found_id_o;
  logic [SRC_W-1:0]     found_source_o;
  logic [OUT_CNT_W-1:0] entry_count_o;

  logic [KEY_W-1:0] table_keys [TABLE_ENTRIES];
  logic [SRC_W-1:0] table_srcs [TABLE_ENTRIES];
  int unsigned      table_count = 0;

  table_reply_t replies_due [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_len = 0;
  int unsigned hold_seq = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned eviction_total = 0;
  int unsigned miss_total = 0;
  int unsigned mismatch_total = 0;

  keyed_table_evict_oldest dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .item_id_i      (item_id_i),
    .source_kind_i  (source_kind_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .evicted_o      (evicted_o),
    .evicted_id_o   (evicted_id_o),
    .found_id_o     (found_id_o),
    .found_source_o (found_source_o),
    .entry_count_o  (entry_count_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // The receiver can be told to hold off for a long stretch; otherwise it stalls at random.
  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= hold_len;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Applies one operation to the table copy and returns the result the block must give.
  function automatic table_reply_t apply_request(input logic [FUNC_W-1:0] f,
                                                 input logic [KEY_W-1:0] id,
                                                 input logic [SRC_W-1:0] src);
    table_reply_t     r;
    int unsigned      pick;
    bit               hit;
    logic [KEY_W-1:0] best;
    logic [SRC_W-1:0] kind;
    r = '0;
    r.status = STATUS_MISS;
    r.found_id = id;
    pick = 0;
    hit = 1'b0;
    best = '0;
    kind = (src == SRC_UNUSED) ? SRC_OTHER : src;
    case (f)
      FUNC_ADD: begin
        if (id != FREE_KEY) begin
          for (int i = 0; i < TABLE_ENTRIES && !hit; i++) begin
            if (table_keys[i] == FREE_KEY) begin
              pick = i;
              hit = 1'b1;
            end
          end
          if (!hit) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
              if (table_keys[i] != FREE_KEY && (!hit || table_keys[i] < best)) begin
                best = table_keys[i];
                pick = i;
                hit = 1'b1;
              end
            end
            r.evicted = 1'b1;
            r.evicted_id = best;
            if (table_count > 0) table_count--;
            eviction_total++;
          end
          table_keys[pick] = id;
          table_srcs[pick] = kind;
          table_count++;
          r.status = STATUS_OK;
          r.slot = SLOT_W'(pick);
          r.found_source = kind;
        end
      end
      FUNC_REMOVE: begin
        if (id != FREE_KEY) begin
          for (int i = 0; i < TABLE_ENTRIES && !hit; i++) begin
            if (table_keys[i] == id) begin
              pick = i;
              hit = 1'b1;
            end
          end
        end
        if (hit) begin
          table_keys[pick] = FREE_KEY;
          if (table_count > 0) table_count--;
          r.status = STATUS_OK;
          r.slot = SLOT_W'(pick);
          r.found_source = table_srcs[pick];
        end
      end
      FUNC_NEWEST: begin
        r.found_id = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (table_keys[i] != FREE_KEY && (!hit || table_keys[i] > best)) begin
            best = table_keys[i];
            pick = i;
            hit = 1'b1;
          end
        end
        if (hit) begin
          r.status = STATUS_OK;
          r.slot = SLOT_W'(pick);
          r.found_id = best;
          r.found_source = table_srcs[pick];
        end
      end
      default: begin
      end
    endcase
    if (r.status == STATUS_MISS) miss_total++;
    r.entry_count = OUT_CNT_W'(table_count);
    return r;
  endfunction

  task automatic report_field(input string field, input logic [KEY_W-1:0] want,
                              input logic [KEY_W-1:0] got);
    mismatch_total++;
    if (mismatch_total <= 10) begin
      $display("mismatch on %s at cycle %0d: expected %h, got %h",
               field, cycle_count, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    table_reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (replies_due.size() == 0) begin
        report_field("unexpected result", '0, found_id_o);
      end else begin
        want = replies_due.pop_front();
        results_checked++;
        if (status_o !== want.status) begin
          report_field("status", KEY_W'(want.status), KEY_W'(status_o));
        end
        if (slot_o !== want.slot) begin
          report_field("slot", KEY_W'(want.slot), KEY_W'(slot_o));
        end
        if (evicted_o !== want.evicted) begin
          report_field("evicted", KEY_W'(want.evicted), KEY_W'(evicted_o));
        end
        if (evicted_id_o !== want.evicted_id) begin
          report_field("evicted_id", want.evicted_id, evicted_id_o);
        end
        if (found_id_o !== want.found_id) report_field("found_id", want.found_id, found_id_o);
        if (found_source_o !== want.found_source) begin
          report_field("found_source", KEY_W'(want.found_source), KEY_W'(found_source_o));
        end
        if (entry_count_o !== want.entry_count) begin
          report_field("entry_count", KEY_W'(want.entry_count), KEY_W'(entry_count_o));
        end
      end
    end
  end

  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] id,
                           input logic [SRC_W-1:0] src);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    item_id_i <= id;
    source_kind_i <= src;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    replies_due.push_back(apply_request(f, id, src));
    items_sent++;
  endtask

  task automatic wait_for_replies();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (replies_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return KEY_W'($urandom_range(15));
    if (roll < 75) return table_keys[$urandom_range(TABLE_ENTRIES - 1)];
    if (roll < 90) return KEY_W'($urandom);
    if (roll < 95) return FREE_KEY;
    return FREE_KEY - KEY_W'($urandom_range(1, 16));
  endfunction

  task automatic send_random_op();
    int unsigned       roll;
    logic [FUNC_W-1:0] f;
    roll = $urandom_range(99);
    if (roll < 45) f = FUNC_ADD;
    else if (roll < 75) f = FUNC_REMOVE;
    else if (roll < 93) f = FUNC_NEWEST;
    else f = FUNC_UNUSED;
    send_item(f, pick_key(), SRC_W'($urandom_range(3)));
  endtask

  task automatic test_empty_table();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_item(FUNC_NEWEST, 32'h0000_0000, SRC_OTHER);
    send_item(FUNC_REMOVE, 32'h0000_0012, SRC_OTHER);
    send_item(FUNC_UNUSED, 32'hA5A5_A5A5, SRC_UNUSED);
    send_item(FUNC_ADD, FREE_KEY, SRC_MAIL);
    send_item(FUNC_REMOVE, FREE_KEY, SRC_OTHER);
    wait_for_replies();
  endtask

  task automatic test_fill_and_evict();
    send_item(FUNC_ADD, 32'h0000_0000, SRC_CHAT);
    send_item(FUNC_ADD, 32'hFFFF_FFFE, SRC_MAIL);
    send_item(FUNC_ADD, 32'h0000_0007, SRC_UNUSED);
    send_item(FUNC_ADD, 32'h0000_0007, SRC_OTHER);
    send_item(FUNC_ADD, 32'h0000_0005, SRC_CHAT);
    send_item(FUNC_ADD, 32'h0000_0005, SRC_MAIL);
    send_item(FUNC_ADD, 32'h0000_0009, SRC_OTHER);
    send_item(FUNC_ADD, 32'h0000_0003, SRC_CHAT);
    send_item(FUNC_NEWEST, 32'h0000_0000, SRC_OTHER);
    send_item(FUNC_ADD, 32'h0000_0064, SRC_MAIL);
    send_item(FUNC_ADD, 32'h0000_0065, SRC_CHAT);
    send_item(FUNC_ADD, 32'h0000_0066, SRC_UNUSED);
    wait_for_replies();
  endtask

  task automatic test_remove_matches();
    send_item(FUNC_REMOVE, 32'h0000_0005, SRC_OTHER);
    send_item(FUNC_REMOVE, 32'h0000_0007, SRC_OTHER);
    send_item(FUNC_REMOVE, 32'h0000_0007, SRC_MAIL);
    send_item(FUNC_REMOVE, 32'h0000_0007, SRC_OTHER);
    send_item(FUNC_REMOVE, 32'hFFFF_FFFE, SRC_OTHER);
    send_item(FUNC_NEWEST, 32'h5A5A_5A5A, SRC_CHAT);
    send_item(FUNC_ADD, FREE_KEY, SRC_UNUSED);
    wait_for_replies();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_random_op();
    wait_for_replies();
  endtask

  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_len = 400;
    hold_seq++;
    repeat (30) send_random_op();
    wait_for_replies();
  endtask

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      table_keys[i] = FREE_KEY;
      table_srcs[i] = SRC_OTHER;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_fill_and_evict();
    test_remove_matches();
    test_random_traffic(0, 0, 150);
    test_random_traffic(88, 0, 150);
    test_random_traffic(0, 88, 150);
    test_random_traffic(10, 10, 150);
    test_output_hold_off();
    repeat (TABLE_ENTRIES + 4) @(posedge clk_i);
    $display("Sent %0d items and checked %0d results, with %0d evictions and %0d misses.",
             items_sent, results_checked, eviction_total, miss_total);
    $display("Idling phases, a long output hold-off and %0d mismatches.", mismatch_total);
    if (mismatch_total == 0 && replies_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
